// ===== rtl/core/sfd_pkg.sv =====
// Package for the scaled field decoder: widths, request/response types, stage records.
package sfd_pkg;

    // Fixed field widths
    localparam int FIELD_W        = 32;
    localparam int LEN_W          = 6;
    localparam int SCALE_W        = 31;
    localparam int IVAL_W         = FIELD_W + 1;
    localparam int VALUE_W        = 64;
    localparam int MODE_W         = 4;
    localparam int SIDX_W         = $clog2(FIELD_W);
    localparam int MAX_FIELD_BITS = 32;

    // Highest permitted representation kind
    localparam logic [MODE_W-1:0] MODE_LAST_VALID = MODE_W'(10);

    // One request item
    typedef struct packed {
        logic [FIELD_W-1:0]        field_bits;
        logic [LEN_W-1:0]          bit_length;
        logic                      is_signed;
        logic [SCALE_W-1:0]        scale_factor;
        logic                      range_enabled;
        logic                      min_inclusive;
        logic                      max_inclusive;
        logic signed [VALUE_W-1:0] range_min;
        logic signed [VALUE_W-1:0] range_max;
        logic [MODE_W-1:0]         value_mode;
    } req_t;

    // One response item
    typedef struct packed {
        logic signed [IVAL_W-1:0]  integer_value;
        logic signed [VALUE_W-1:0] decoded_value;
        logic                      out_of_range;
        logic                      bad_mode;
    } rsp_t;

    // Range check settings carried down the pipe
    typedef struct packed {
        logic                      enabled;
        logic                      min_inclusive;
        logic                      max_inclusive;
        logic signed [VALUE_W-1:0] range_min;
        logic signed [VALUE_W-1:0] range_max;
    } range_t;

    // Field decoder result
    typedef struct packed {
        logic signed [IVAL_W-1:0] ival;
        logic                     bad_mode;
    } dec_t;

    // Stage 1: decoded integer
    typedef struct packed {
        logic signed [IVAL_W-1:0] ival;
        logic [SCALE_W-1:0]       scale;
        range_t                   rng;
        logic                     bad_mode;
    } s1_t;

    // Stage 2: scaled product
    typedef struct packed {
        logic signed [IVAL_W-1:0]  ival;
        logic signed [VALUE_W-1:0] prod;
        range_t                    rng;
        logic                      bad_mode;
    } s2_t;

endpackage

// ===== rtl/core/sfd_decode.sv =====
// Field decoder: length clamp, spare-bit masking, sign extension and mode check.
module sfd_decode
    import sfd_pkg::*;
(
    input  req_t req,
    output dec_t dec
);

    logic [LEN_W-1:0]  len;
    logic [SIDX_W-1:0] sidx;
    logic              neg;

    // Clamp the length into 1..MAX_FIELD_BITS
    always_comb
    begin
        priority if (req.bit_length == '0)
        begin
            len = LEN_W'(1);
        end
        else if (req.bit_length > LEN_W'(MAX_FIELD_BITS))
        begin
            len = LEN_W'(MAX_FIELD_BITS);
        end
        else
        begin
            len = req.bit_length;
        end
    end

    // Sign bit sits at the top of the field
    assign sidx = SIDX_W'(len - LEN_W'(1));
    assign neg  = req.is_signed & req.field_bits[sidx];

    // Keep bits below the length, fill the rest with the sign; flag modes above the last kind
    always_comb
    begin
        for (int i = 0; i < FIELD_W; i++)
        begin
            if (LEN_W'(i) < len)
            begin
                dec.ival[i] = req.field_bits[i];
            end
            else
            begin
                dec.ival[i] = neg;
            end
        end
        dec.ival[IVAL_W-1] = neg;
        dec.bad_mode       = (req.value_mode > MODE_LAST_VALID);
    end

endmodule

// ===== rtl/core/scaled_field_decode_range_check.sv =====
// Scaled field decoder with range check: three-stage pipeline, top level.
// Stages in order: decode into s1_reg, multiply into s2_reg, compare into rsp_reg.
// One request per cycle unless stalled; the 33x32 signed multiply in stage 2 sets the stage depth.
// A stalled response holds its stage; earlier stages keep filling bubbles, then stall.
// Reset (rst_n low, asynchronous) empties all stages; payload registers are not reset.
module scaled_field_decode_range_check
    import sfd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req_data,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp_data
);

    logic s1_valid_reg;
    logic s2_valid_reg;
    logic rsp_valid_reg;
    s1_t  s1_reg;
    s1_t  s1_next;
    s2_t  s2_reg;
    s2_t  s2_next;
    rsp_t rsp_reg;
    rsp_t rsp_next;
    dec_t dec;
    logic en1;
    logic en2;
    logic en3;
    logic signed [IVAL_W+SCALE_W:0] prod_full;
    logic lo_ok;
    logic hi_ok;

    // Stage advance: a stage moves when empty or when the next one moves
    assign en3       = !rsp_valid_reg || !rsp_stall;
    assign en2       = !s2_valid_reg || en3;
    assign en1       = !s1_valid_reg || en2;
    assign req_stall = !en1;

    // Stage 1: field decode
    sfd_decode u_decode (
        .req (req_data),
        .dec (dec)
    );

    always_comb
    begin
        s1_next.ival              = dec.ival;
        s1_next.scale             = req_data.scale_factor;
        s1_next.rng.enabled       = req_data.range_enabled;
        s1_next.rng.min_inclusive = req_data.min_inclusive;
        s1_next.rng.max_inclusive = req_data.max_inclusive;
        s1_next.rng.range_min     = req_data.range_min;
        s1_next.rng.range_max     = req_data.range_max;
        s1_next.bad_mode          = dec.bad_mode;
    end

    // Stage 2: exact signed product, fits in 64 bits
    assign prod_full = s1_reg.ival * $signed({1'b0, s1_reg.scale});

    always_comb
    begin
        s2_next.ival     = s1_reg.ival;
        s2_next.prod     = prod_full[VALUE_W-1:0];
        s2_next.rng      = s1_reg.rng;
        s2_next.bad_mode = s1_reg.bad_mode;
    end

    // Stage 3: range check against inclusive or exclusive bounds
    always_comb
    begin
        if (s2_reg.rng.min_inclusive)
        begin
            lo_ok = (s2_reg.prod >= s2_reg.rng.range_min);
        end
        else
        begin
            lo_ok = (s2_reg.prod > s2_reg.rng.range_min);
        end
        if (s2_reg.rng.max_inclusive)
        begin
            hi_ok = (s2_reg.prod <= s2_reg.rng.range_max);
        end
        else
        begin
            hi_ok = (s2_reg.prod < s2_reg.rng.range_max);
        end
    end

    always_comb
    begin
        rsp_next.integer_value = s2_reg.ival;
        rsp_next.decoded_value = s2_reg.prod;
        rsp_next.out_of_range  = s2_reg.rng.enabled && !(lo_ok && hi_ok);
        rsp_next.bad_mode      = s2_reg.bad_mode;
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                s1_valid_reg <= req_valid;
            end
            if (en2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (en3)
            begin
                rsp_valid_reg <= s2_valid_reg;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_reg <= s1_next;
        end
        if (en2)
        begin
            s2_reg <= s2_next;
        end
        if (en3)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    // A zero integer always scales to zero
    a_zero_product: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_data.integer_value == '0) |-> (rsp_data.decoded_value == '0))
        else $error("nonzero product from zero integer");

    // A non-negative integer never scales to a negative value
    a_sign_kept: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_data.integer_value[IVAL_W-1] |-> !rsp_data.decoded_value[VALUE_W-1])
        else $error("negative product from non-negative integer");

    // A full pipe with a stalled response must stall requests
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s2_valid_reg && rsp_valid && rsp_stall |-> req_stall)
        else $error("request taken while pipe full and stalled");

endmodule

// ===== sim/scaled_field_decode_range_check_tb.sv =====
// Testbench for the scaled field decoder: directed table, random requests, scoreboard check.
module scaled_field_decode_range_check_tb;
    import sfd_pkg::*;

    // Representation kinds used by name
    localparam logic [MODE_W-1:0] MODE_PLAIN    = '0;
    localparam logic [MODE_W-1:0] MODE_FIRST_BAD = MODE_LAST_VALID + 1'b1;
    localparam logic [MODE_W-1:0] MODE_TOP      = '1;

    // Scale of 1.0 in Q7.24, and the largest scale
    localparam logic [SCALE_W-1:0] SCALE_ONE = 31'h0100_0000;
    localparam logic [SCALE_W-1:0] SCALE_MAX = '1;

    localparam logic [VALUE_W-1:0] Q_MOST_NEG = 64'h8000_0000_0000_0000;
    localparam logic [VALUE_W-1:0] Q_MOST_POS = 64'h7FFF_FFFF_FFFF_FFFF;

    localparam int RAND_PER_PHASE = 350;

    typedef struct {
        req_t req;
        bit   known;
        rsp_t want;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req_data;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp_data;

    rsp_t     pending_rsp_q[$];
    dir_row_t dir_rows[$];
    int       err_count = 0;
    int       send_idle_pct = 0;
    int       rsp_stall_pct = 0;

    scaled_field_decode_range_check uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

    // Decode, scale and range check of one field
    function automatic rsp_t predict_decode(input req_t r);
        int          len;
        logic [63:0] field;
        logic [63:0] mag;
        logic [63:0] ival;
        logic [63:0] prod;
        logic signed [63:0] sprod;
        logic        neg;
        logic        lo_ok;
        logic        hi_ok;
        rsp_t        o;
        len = r.bit_length;
        if (len < 1)
            len = 1;
        if (len > MAX_FIELD_BITS)
            len = MAX_FIELD_BITS;
        field = {32'b0, r.field_bits} & ((64'd1 << len) - 64'd1);
        neg   = r.is_signed && field[len-1];
        mag   = neg ? ((64'd1 << len) - field) : field;
        ival  = neg ? (64'd0 - mag) : mag;
        prod  = mag * {33'b0, r.scale_factor};
        if (neg)
            prod = 64'd0 - prod;
        sprod = prod;
        lo_ok = r.min_inclusive ? (sprod >= r.range_min) : (sprod > r.range_min);
        hi_ok = r.max_inclusive ? (sprod <= r.range_max) : (sprod < r.range_max);
        o.integer_value = ival[IVAL_W-1:0];
        o.decoded_value = sprod;
        o.out_of_range  = r.range_enabled && !(lo_ok && hi_ok);
        o.bad_mode      = r.value_mode > MODE_LAST_VALID;
        return o;
    endfunction

    function automatic req_t mk_req(input logic [FIELD_W-1:0] fbits, input logic [LEN_W-1:0] len,
                                    input logic sgn, input logic [SCALE_W-1:0] scale,
                                    input logic ren, input logic minc, input logic maxc,
                                    input logic [VALUE_W-1:0] rmin, input logic [VALUE_W-1:0] rmax,
                                    input logic [MODE_W-1:0] mode);
        req_t r;
        r.field_bits    = fbits;
        r.bit_length    = len;
        r.is_signed     = sgn;
        r.scale_factor  = scale;
        r.range_enabled = ren;
        r.min_inclusive = minc;
        r.max_inclusive = maxc;
        r.range_min     = rmin;
        r.range_max     = rmax;
        r.value_mode    = mode;
        return r;
    endfunction

    function automatic rsp_t mk_rsp(input logic [IVAL_W-1:0] ival, input logic [VALUE_W-1:0] dec,
                                    input logic oor, input logic bad);
        rsp_t o;
        o.integer_value = ival;
        o.decoded_value = dec;
        o.out_of_range  = oor;
        o.bad_mode      = bad;
        return o;
    endfunction

    task automatic add_row(input req_t r, input bit known, input rsp_t want);
        dir_row_t row;
        row.req   = r;
        row.known = known;
        row.want  = want;
        dir_rows.push_back(row);
    endtask

    // Bound near the decoded value, or anywhere
    function automatic logic [VALUE_W-1:0] pick_bound(input logic [VALUE_W-1:0] base);
        case ($urandom_range(6))
            0: return {$urandom, $urandom};
            1: return base;
            2: return base - 64'd1;
            3: return base + 64'd1;
            4: return Q_MOST_NEG;
            5: return Q_MOST_POS;
            default: return base + {{32{1'b0}}, $urandom} - {{32{1'b0}}, $urandom};
        endcase
    endfunction

    function automatic req_t random_req();
        req_t r;
        r.field_bits = $urandom;
        case ($urandom_range(9))
            0: r.bit_length = '0;
            1: r.bit_length = LEN_W'($urandom_range(63, 33));
            default: r.bit_length = LEN_W'($urandom_range(32, 1));
        endcase
        r.is_signed = 1'($urandom_range(1));
        case ($urandom_range(7))
            0: r.scale_factor = '0;
            1: r.scale_factor = SCALE_MAX;
            2: r.scale_factor = SCALE_ONE;
            3: r.scale_factor = SCALE_W'($urandom_range(255));
            default: r.scale_factor = SCALE_W'($urandom);
        endcase
        r.range_enabled = ($urandom_range(3) != 0);
        r.min_inclusive = 1'($urandom_range(1));
        r.max_inclusive = 1'($urandom_range(1));
        r.range_min     = '0;
        r.range_max     = '0;
        r.value_mode    = MODE_W'($urandom_range(15));
        r.range_min     = pick_bound(predict_decode(r).decoded_value);
        r.range_max     = pick_bound(predict_decode(r).decoded_value);
        return r;
    endfunction

    // Present one request, hold it until taken, then queue its result
    task automatic drive_req(input req_t r, input bit known, input rsp_t want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        pending_rsp_q.push_back(known ? want : predict_decode(r));
    endtask

    task automatic report_mismatch(input string msg);
        $display("%0t: mismatch: %s", $time, msg);
        err_count++;
    endtask

    // Receiver stall
    always @(posedge clk)
    begin
        rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
    end

    // Response check against the oldest pending result
    always @(posedge clk)
    begin : check_rsp
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_rsp_q.size() == 0)
                report_mismatch("response with no request pending");
            else
            begin
                want = pending_rsp_q.pop_front();
                if (rsp_data.integer_value !== want.integer_value)
                    report_mismatch($sformatf("integer_value %h, want %h",
                                              rsp_data.integer_value, want.integer_value));
                if (rsp_data.decoded_value !== want.decoded_value)
                    report_mismatch($sformatf("decoded_value %h, want %h",
                                              rsp_data.decoded_value, want.decoded_value));
                if (rsp_data.out_of_range !== want.out_of_range)
                    report_mismatch($sformatf("out_of_range %b, want %b",
                                              rsp_data.out_of_range, want.out_of_range));
                if (rsp_data.bad_mode !== want.bad_mode)
                    report_mismatch($sformatf("bad_mode %b, want %b",
                                              rsp_data.bad_mode, want.bad_mode));
            end
        end
    end

    initial
    begin : main
        rsp_t none;
        int   idle_tab[5];
        int   stall_tab[5];
        none      = '0;
        idle_tab  = '{0, 76, 0, 17, 0};
        stall_tab = '{0, 0, 76, 17, 0};
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req_data  <= '0;

        // Directed table
        // Extremes of value and scale
        add_row(mk_req(32'hFF, 6'd8, 1'b0, SCALE_ONE, 1'b0, 1'b0, 1'b0, '0, '0, MODE_PLAIN),
                1'b1, mk_rsp(33'h0_0000_00FF, 64'h0000_0000_FF00_0000, 1'b0, 1'b0));
        add_row(mk_req(32'hFF, 6'd8, 1'b1, SCALE_ONE, 1'b0, 1'b0, 1'b0, '0, '0, MODE_PLAIN),
                1'b1, mk_rsp(33'h1_FFFF_FFFF, 64'hFFFF_FFFF_FF00_0000, 1'b0, 1'b0));
        add_row(mk_req(32'h8000_0000, 6'd32, 1'b1, SCALE_MAX, 1'b0, 1'b0, 1'b0, '0, '0, MODE_PLAIN),
                1'b1, mk_rsp(33'h1_8000_0000, 64'hC000_0000_8000_0000, 1'b0, 1'b0));
        add_row(mk_req(32'hFFFF_FFFF, 6'd32, 1'b0, SCALE_MAX, 1'b0, 1'b0, 1'b0, '0, '0, MODE_PLAIN),
                1'b1, mk_rsp(33'h0_FFFF_FFFF, 64'h7FFF_FFFE_8000_0001, 1'b0, 1'b0));
        // Zero length reads as one bit
        add_row(mk_req(32'hFFFF_FFFF, 6'd0, 1'b1, '0, 1'b0, 1'b0, 1'b0, '0, '0, MODE_PLAIN),
                1'b1, mk_rsp(33'h1_FFFF_FFFF, 64'h0, 1'b0, 1'b0));
        // Overlong lengths clip to the full field
        add_row(mk_req(32'h8000_0001, 6'd63, 1'b1, SCALE_ONE, 1'b0, 1'b0, 1'b0, '0, '0, MODE_PLAIN),
                1'b0, none);
        add_row(mk_req(32'hFFFF_FFFF, 6'd33, 1'b0, SCALE_MAX, 1'b0, 1'b0, 1'b0, '0, '0, MODE_PLAIN),
                1'b0, none);
        // Spare bits above the length are dropped
        add_row(mk_req(32'hABCD_1234, 6'd4, 1'b0, SCALE_ONE, 1'b0, 1'b0, 1'b0, '0, '0, MODE_PLAIN),
                1'b1, mk_rsp(33'h0_0000_0004, 64'h0000_0000_0400_0000, 1'b0, 1'b0));
        add_row(mk_req(32'hFFFF_FFF7, 6'd4, 1'b1, SCALE_ONE, 1'b0, 1'b0, 1'b0, '0, '0, MODE_PLAIN),
                1'b0, none);
        add_row(mk_req(32'h1, 6'd1, 1'b1, 31'h123_4567, 1'b0, 1'b0, 1'b0, '0, '0, MODE_PLAIN),
                1'b0, none);
        // Mode check
        add_row(mk_req(32'h1, 6'd1, 1'b0, 31'd1, 1'b0, 1'b0, 1'b0, '0, '0, MODE_FIRST_BAD),
                1'b1, mk_rsp(33'h1, 64'h1, 1'b0, 1'b1));
        add_row(mk_req(32'h1, 6'd1, 1'b0, 31'd1, 1'b0, 1'b0, 1'b0, '0, '0, MODE_TOP),
                1'b1, mk_rsp(33'h1, 64'h1, 1'b0, 1'b1));
        add_row(mk_req(32'h1, 6'd1, 1'b0, 31'd1, 1'b0, 1'b0, 1'b0, '0, '0, MODE_LAST_VALID),
                1'b1, mk_rsp(33'h1, 64'h1, 1'b0, 1'b0));
        // Value on the bounds, inclusive and exclusive
        add_row(mk_req(32'h1, 6'd1, 1'b0, 31'd1, 1'b1, 1'b1, 1'b1, 64'd1, 64'd1, MODE_PLAIN),
                1'b1, mk_rsp(33'h1, 64'h1, 1'b0, 1'b0));
        add_row(mk_req(32'h1, 6'd1, 1'b0, 31'd1, 1'b1, 1'b0, 1'b1, 64'd1, 64'd9, MODE_PLAIN),
                1'b1, mk_rsp(33'h1, 64'h1, 1'b1, 1'b0));
        add_row(mk_req(32'h1, 6'd1, 1'b0, 31'd1, 1'b1, 1'b1, 1'b0, 64'd0, 64'd1, MODE_PLAIN),
                1'b1, mk_rsp(33'h1, 64'h1, 1'b1, 1'b0));
        // Inverted range rejects everything; disabled range rejects nothing
        add_row(mk_req(32'h1, 6'd1, 1'b0, 31'd1, 1'b1, 1'b1, 1'b1, 64'd5, -64'sd5, MODE_PLAIN),
                1'b1, mk_rsp(33'h1, 64'h1, 1'b1, 1'b0));
        add_row(mk_req(32'h1, 6'd1, 1'b0, 31'd1, 1'b0, 1'b1, 1'b1, 64'd5, -64'sd5, MODE_PLAIN),
                1'b0, none);
        // Extreme bounds
        add_row(mk_req(32'h8000_0000, 6'd32, 1'b1, SCALE_MAX, 1'b1, 1'b1, 1'b1,
                       Q_MOST_NEG, Q_MOST_POS, MODE_PLAIN), 1'b0, none);
        add_row(mk_req(32'hFFFF_FFFF, 6'd32, 1'b0, SCALE_MAX, 1'b1, 1'b0, 1'b0,
                       Q_MOST_NEG, 64'h7FFF_FFFE_8000_0001, MODE_PLAIN), 1'b0, none);
        add_row(mk_req(32'h0, 6'd32, 1'b1, SCALE_MAX, 1'b1, 1'b0, 1'b1, 64'd0, Q_MOST_POS,
                       MODE_PLAIN), 1'b0, none);

        // Reset
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            drive_req(dir_rows[i].req, dir_rows[i].known, dir_rows[i].want);

        // Random requests, one phase per idling pattern
        for (int ph = 0; ph < 5; ph++)
        begin
            send_idle_pct = idle_tab[ph];
            rsp_stall_pct = stall_tab[ph];
            for (int n = 0; n < RAND_PER_PHASE; n++)
                drive_req(random_req(), 1'b0, none);
        end
        req_valid <= 1'b0;
        rsp_stall_pct = 0;

        // Drain, then watch for stray responses
        while (pending_rsp_q.size() != 0)
            @(posedge clk);
        repeat (10)
            @(posedge clk);
        if (err_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
